// ===== sv/tbfc_pkg.sv =====
// Shared constants, types and rounding helper for the three-band FIR crossover.
// No dependencies; every other file depends on this package.
package tbfc_pkg;

    localparam int TAPS      = 1023;
    localparam int CHANNELS  = 2;
    localparam int DATA_W    = 24;
    localparam int FRAC_W    = 23;
    localparam int TAP_W     = $clog2(TAPS);
    localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_D    = CHANNELS * TAPS;
    localparam int HA_W      = $clog2(HIST_D);
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + TAP_W;
    localparam int RES_W     = ACC_W + 1;
    localparam int HALF_DLY  = (TAPS - 1) / 2;

    localparam logic [1:0] MODE_SAMPLE   = 2'd0;
    localparam logic [1:0] MODE_LOW_TAP  = 2'd1;
    localparam logic [1:0] MODE_HIGH_TAP = 2'd2;

    localparam logic signed [RES_W-1:0] HALF_LSB = RES_W'(2 ** (FRAC_W - 1));
    localparam logic signed [RES_W-1:0] SAT_HI   = RES_W'(8388607);
    localparam logic signed [RES_W-1:0] SAT_LO   = RES_W'(-8388608);

    typedef struct packed {
        logic clr;   // clear accumulators
        logic mac;   // memory read data carries one tap product
        logic dly;   // memory read data carries the delayed sample
    } mac_ctl_t;

    // floor(x / 2^23 + 1/2), saturated to 24 bits signed
    function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [RES_W-1:0] x);
        logic signed [RES_W-1:0] t;
        logic signed [RES_W-1:0] q;
        t = x + HALF_LSB;
        q = t >>> FRAC_W;
        if (q > SAT_HI)
            q = SAT_HI;
        else if (q < SAT_LO)
            q = SAT_LO;
        return q[DATA_W-1:0];
    endfunction

endpackage

// ===== sv/tbfc_in_if.sv =====
// Input channel: sample or tap coefficient word with valid/ready.
// Depends on tbfc_pkg.
interface tbfc_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          mode;
    logic                                channel;
    logic [9:0]                          tap_index;
    logic signed [tbfc_pkg::DATA_W-1:0]  value;

    modport source (output valid, mode, channel, tap_index, value, input ready);
    modport sink   (input valid, mode, channel, tap_index, value, output ready);
endinterface

// ===== sv/tbfc_out_if.sv =====
// Output channel: three band samples of one channel with valid/ready.
// Depends on tbfc_pkg.
interface tbfc_out_if;
    logic                                valid;
    logic                                ready;
    logic                                out_channel;
    logic signed [tbfc_pkg::DATA_W-1:0]  low_band;
    logic signed [tbfc_pkg::DATA_W-1:0]  mid_band;
    logic signed [tbfc_pkg::DATA_W-1:0]  high_band;

    modport source (output valid, out_channel, low_band, mid_band, high_band, input ready);
    modport sink   (input valid, out_channel, low_band, mid_band, high_band, output ready);
endinterface

// ===== sv/three_band_fir_crossover_top.sv =====
// Three-band FIR crossover top level. A sample word runs through the MAC loop
// with one memory read per tap, then one center read, pipeline drain and two
// finishing states; the second waits for the output register to be free.
// Tap words are written while idle, and the block stays ready for the next word.
// After reset the block clears history and tap memories before it accepts any word. Results wait in an output register.
// Depends on tbfc_pkg, tbfc_in_if, tbfc_out_if and tbfc_mac.
module three_band_fir_crossover_top (
    input  logic        clk,
    input  logic        rst_n,
    tbfc_in_if.sink     din,
    tbfc_out_if.source  dout
);
    import tbfc_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MAC   = 7'b0000100,
        S_DLY   = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_FIN1  = 7'b0100000,
        S_FIN2  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // memories
    logic signed [DATA_W-1:0] hist_mem [HIST_D];
    logic signed [DATA_W-1:0] lo_mem   [TAPS];
    logic signed [DATA_W-1:0] hi_mem   [TAPS];
    logic signed [DATA_W-1:0] hist_q, lo_q, hi_q;

    logic                     hist_we, lo_we, hi_we;
    logic [HA_W-1:0]          hist_waddr, hist_raddr;
    logic [TAP_W-1:0]         tap_waddr;
    logic signed [DATA_W-1:0] wdata;

    // control
    logic [HA_W-1:0]          clr_cnt_reg;
    logic [TAP_W-1:0]         ptr_reg [CHANNELS];
    logic [TAP_W-1:0]         k_reg, pos_reg, dpos_reg;
    logic [HA_W-1:0]          base_reg;
    logic                     ch_reg;
    logic                     rd_mac_reg, rd_dly_reg;

    logic                     accept, chan_ok, idx_ok, sample_acc;
    logic [CH_IDX_W-1:0]      ch_idx;
    logic [TAP_W-1:0]         ptr_cur;
    logic [HA_W-1:0]          base_in;
    logic [TAP_W:0]           dpos_sum;
    logic [TAP_W-1:0]         dpos_in;
    logic                     clr_taps;

    // finishing
    logic signed [ACC_W-1:0]  acc_lo, acc_hi;
    logic signed [DATA_W-1:0] dly;
    logic                     mac_busy;
    mac_ctl_t                 mac_ctl;
    logic signed [RES_W-1:0]  res_lo_reg, res_mid_reg, res_high_reg;

    logic                     out_vld_reg;
    logic                     out_ch_reg;
    logic signed [DATA_W-1:0] low_reg, mid_reg, high_reg;
    logic                     out_load;

    assign din.ready  = (state_reg == S_IDLE);
    assign accept     = din.valid && din.ready;
    assign chan_ok    = (32'(din.channel) < CHANNELS);
    assign idx_ok     = (32'(din.tap_index) < TAPS);
    assign sample_acc = accept && (din.mode == MODE_SAMPLE) && chan_ok;
    assign ch_idx     = CH_IDX_W'(din.channel);
    assign ptr_cur    = ptr_reg[ch_idx];
    assign base_in    = HA_W'(32'(ch_idx) * TAPS);
    assign dpos_sum   = (TAP_W + 1)'(ptr_cur) + (TAP_W + 1)'(TAPS - HALF_DLY);
    assign dpos_in    = (32'(dpos_sum) >= TAPS) ? TAP_W'(32'(dpos_sum) - TAPS)
                                                 : dpos_sum[TAP_W-1:0];
    assign clr_taps   = (state_reg == S_CLEAR) && (32'(clr_cnt_reg) < TAPS);

    // memory write ports: clearing pass, sample store, tap loads
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            hist_we    = 1'b1;
            hist_waddr = clr_cnt_reg;
            tap_waddr  = clr_cnt_reg[TAP_W-1:0];
            wdata      = '0;
            lo_we      = clr_taps;
            hi_we      = clr_taps;
        end
        else
        begin
            hist_we    = sample_acc;
            hist_waddr = base_in + HA_W'(ptr_cur);
            tap_waddr  = TAP_W'(din.tap_index);
            wdata      = din.value;
            lo_we      = accept && (din.mode == MODE_LOW_TAP) && idx_ok;
            hi_we      = accept && (din.mode == MODE_HIGH_TAP) && idx_ok;
        end
    end

    assign hist_raddr = (state_reg == S_DLY) ? base_reg + HA_W'(dpos_reg)
                                             : base_reg + HA_W'(pos_reg);

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[hist_waddr] <= wdata;
        hist_q <= hist_mem[hist_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lo_we)
            lo_mem[tap_waddr] <= wdata;
        lo_q <= lo_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hi_we)
            hi_mem[tap_waddr] <= wdata;
        hi_q <= hi_mem[k_reg];
    end

    assign mac_ctl.clr = sample_acc;
    assign mac_ctl.mac = rd_mac_reg;
    assign mac_ctl.dly = rd_dly_reg;

    tbfc_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .x      (hist_q),
        .lo_tap (lo_q),
        .hi_tap (hi_q),
        .acc_lo (acc_lo),
        .acc_hi (acc_hi),
        .dly    (dly),
        .busy   (mac_busy)
    );

    assign out_load = (state_reg == S_FIN2) && (!out_vld_reg || dout.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == HA_W'(HIST_D - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (sample_acc)
                    state_next = S_MAC;
            end
            S_MAC:
            begin
                if (k_reg == TAP_W'(TAPS - 1))
                    state_next = S_DLY;
            end
            S_DLY:
                state_next = S_DRAIN;
            S_DRAIN:
            begin
                // wait until the last product and the center sample have landed
                if (!rd_mac_reg && !rd_dly_reg && !mac_busy)
                    state_next = S_FIN1;
            end
            S_FIN1:
                state_next = S_FIN2;
            S_FIN2:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            rd_mac_reg  <= 1'b0;
            rd_dly_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
                ptr_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_mac_reg <= (state_reg == S_MAC);
            rd_dly_reg <= (state_reg == S_DLY);
            if (state_reg == S_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (sample_acc)
                ptr_reg[ch_idx] <= (ptr_cur == TAP_W'(TAPS - 1)) ? '0 : ptr_cur + 1'b1;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (dout.ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            k_reg    <= '0;
            pos_reg  <= ptr_cur;
            dpos_reg <= dpos_in;
            base_reg <= base_in;
            ch_reg   <= din.channel;
        end
        else if (state_reg == S_MAC)
        begin
            // advance tap index, walk history backward with wrap
            k_reg   <= k_reg + 1'b1;
            pos_reg <= (pos_reg == '0) ? TAP_W'(TAPS - 1) : pos_reg - 1'b1;
        end

        if (state_reg == S_FIN1)
        begin
            res_lo_reg   <= RES_W'(acc_lo);
            res_mid_reg  <= RES_W'(acc_hi) - RES_W'(acc_lo);
            res_high_reg <= (RES_W'(dly) <<< FRAC_W) - RES_W'(acc_hi);
        end

        if (out_load)
        begin
            out_ch_reg <= ch_reg;
            low_reg    <= round_sat(res_lo_reg);
            mid_reg    <= round_sat(res_mid_reg);
            high_reg   <= round_sat(res_high_reg);
        end
    end

    assign dout.valid       = out_vld_reg;
    assign dout.out_channel = out_ch_reg;
    assign dout.low_band    = low_reg;
    assign dout.mid_band    = mid_reg;
    assign dout.high_band   = high_reg;

endmodule

// ===== sv/tbfc_mac.sv =====
// Dual multiply-accumulate datapath: registered products, two accumulators
// and capture of the delayed center sample. Depends on tbfc_pkg.
module tbfc_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  tbfc_pkg::mac_ctl_t                 ctl,
    input  logic signed [tbfc_pkg::DATA_W-1:0] x,
    input  logic signed [tbfc_pkg::DATA_W-1:0] lo_tap,
    input  logic signed [tbfc_pkg::DATA_W-1:0] hi_tap,
    output logic signed [tbfc_pkg::ACC_W-1:0]  acc_lo,
    output logic signed [tbfc_pkg::ACC_W-1:0]  acc_hi,
    output logic signed [tbfc_pkg::DATA_W-1:0] dly,
    output logic                               busy
);
    import tbfc_pkg::*;

    logic                      mul_vld_reg;
    logic signed [PROD_W-1:0]  prod_lo_reg;
    logic signed [PROD_W-1:0]  prod_hi_reg;
    logic signed [ACC_W-1:0]   acc_lo_reg;
    logic signed [ACC_W-1:0]   acc_hi_reg;
    logic signed [DATA_W-1:0]  dly_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else
            mul_vld_reg <= ctl.mac;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mac)
        begin
            prod_lo_reg <= lo_tap * x;
            prod_hi_reg <= hi_tap * x;
        end
        if (ctl.dly)
            dly_reg <= x;
        if (ctl.clr)
        begin
            acc_lo_reg <= '0;
            acc_hi_reg <= '0;
        end
        else if (mul_vld_reg)
        begin
            acc_lo_reg <= acc_lo_reg + ACC_W'(prod_lo_reg);
            acc_hi_reg <= acc_hi_reg + ACC_W'(prod_hi_reg);
        end
    end

    assign acc_lo = acc_lo_reg;
    assign acc_hi = acc_hi_reg;
    assign dly    = dly_reg;
    assign busy   = mul_vld_reg;

endmodule

// ===== sim/tb_three_band_fir_crossover_top.sv =====
// Self-checking bench for the three-band FIR crossover: directed edges, a tap load, then a long
// random stream. It predicts each band triple from its own copy of history and taps.
// Depends on tbfc_pkg, tbfc_in_if, tbfc_out_if and the three_band_fir_crossover_top RTL.
module tb_three_band_fir_crossover_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tbfc_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MAX  = 24'sh7FFFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN  = 24'sh800000;
    localparam logic signed [DATA_W-1:0] VAL_HALF = 24'sh400000;
    localparam logic [9:0] IDX_LAST = 10'(TAPS - 1);
    localparam logic [9:0] IDX_OUT  = 10'(TAPS);

    localparam longint BAND_MAX = 64'sd8388607;
    localparam longint BAND_MIN = -64'sd8388608;

    localparam int COEF_WORDS    = 30;
    localparam int STREAM_WORDS  = 500;
    localparam int DRAIN_CYCLES  = 20000;
    localparam int FINISH_CYCLES = 1100;

    typedef struct {
        logic                     channel;
        logic signed [DATA_W-1:0] low;
        logic signed [DATA_W-1:0] mid;
        logic signed [DATA_W-1:0] high;
    } bands_t;

    logic clk;
    logic rst_n;

    tbfc_in_if  sample_bus();
    tbfc_out_if band_bus();

    three_band_fir_crossover_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (sample_bus),
        .dout  (band_bus)
    );

    // crossover state as the bench sees it
    logic signed [DATA_W-1:0] history   [CHANNELS][TAPS];
    logic signed [DATA_W-1:0] low_coef  [TAPS];
    logic signed [DATA_W-1:0] high_coef [TAPS];
    int unsigned              write_slot[CHANNELS];

    bands_t expected_bands[$];

    int fail_count;
    int bands_checked;
    int coef_writes;
    int ignored_words;
    int samples_sent[CHANNELS];
    bit sender_gaps;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // floor(acc / 2^23 + 1/2), clamped to 24 bits signed
    function automatic logic signed [DATA_W-1:0] band_round(input longint acc);
        longint q;
        q = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (q > BAND_MAX)
            q = BAND_MAX;
        if (q < BAND_MIN)
            q = BAND_MIN;
        return q[DATA_W-1:0];
    endfunction

    task automatic predict_word(input logic [1:0] mode, input logic ch,
                                input logic [9:0] idx, input logic signed [DATA_W-1:0] val);
        bands_t      b;
        longint      acc_lo;
        longint      acc_hi;
        longint      delayed;
        int unsigned slot;
        int unsigned pos;
        int unsigned dpos;
        if (mode == MODE_LOW_TAP || mode == MODE_HIGH_TAP)
        begin
            if (int'(idx) < TAPS)
            begin
                if (mode == MODE_LOW_TAP)
                    low_coef[idx] = val;
                else
                    high_coef[idx] = val;
                coef_writes++;
            end
            else
                ignored_words++;
        end
        else if (mode != MODE_SAMPLE || int'(ch) >= CHANNELS)
            ignored_words++;
        else
        begin
            slot = write_slot[ch];
            if (slot >= TAPS)
                slot = 0;
            history[ch][slot] = val;
            acc_lo = 0;
            acc_hi = 0;
            pos    = slot;
            for (int k = 0; k < TAPS; k++)
            begin
                acc_lo += longint'(low_coef[k]) * longint'(history[ch][pos]);
                acc_hi += longint'(high_coef[k]) * longint'(history[ch][pos]);
                pos = (pos == 0) ? TAPS - 1 : pos - 1;
            end
            // center of the history window, HALF_DLY samples back
            dpos = slot + TAPS - HALF_DLY;
            if (dpos >= TAPS)
                dpos -= TAPS;
            delayed = longint'(history[ch][dpos]);
            write_slot[ch] = (slot + 1 >= TAPS) ? 0 : slot + 1;

            b.channel = ch;
            b.low     = band_round(acc_lo);
            b.mid     = band_round(acc_hi - acc_lo);
            b.high    = band_round((delayed <<< FRAC_W) - acc_hi);
            expected_bands.push_back(b);
            samples_sent[ch]++;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_gaps || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 3);
        if (r < 90)
            return $urandom_range(4, 60);
        return $urandom_range(200, 1500);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return DATA_W'($urandom);
        if (r < 75)
            return DATA_W'(int'($urandom_range(0, 131072)) - 65536);
        if (r < 85)
            return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        return DATA_W'(int'($urandom_range(0, 16)) - 8);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return DATA_W'(int'($urandom_range(0, 32768)) - 16384);
        if (r < 70)
            return DATA_W'(int'($urandom_range(0, 2097152)) - 1048576);
        if (r < 95)
            return DATA_W'($urandom);
        return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    endfunction

    // offer one word after a random gap and hold it until accepted
    task automatic send_word(input logic [1:0] mode, input logic ch,
                             input logic [9:0] idx, input logic signed [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            sample_bus.valid <= 1'b0;
        end
        @(negedge clk);
        sample_bus.valid     <= 1'b1;
        sample_bus.mode      <= mode;
        sample_bus.channel   <= ch;
        sample_bus.tap_index <= idx;
        sample_bus.value     <= val;
        do
            @(posedge clk);
        while (!sample_bus.ready);
        predict_word(mode, ch, idx, val);
    endtask

    task automatic test_directed_edges();
        // all taps zero: every band must be zero
        send_word(MODE_SAMPLE, 1'b0, 10'd0, VAL_MAX);
        send_word(MODE_SAMPLE, 1'b1, IDX_LAST, VAL_MIN);
        // half tap: exercise round half up on both signs
        send_word(MODE_LOW_TAP, 1'b0, 10'd0, VAL_HALF);
        send_word(MODE_SAMPLE, 1'b0, 10'd0, 24'sd1);
        send_word(MODE_SAMPLE, 1'b0, 10'd0, -24'sd1);
        // full-scale taps at both ends of the tables
        send_word(MODE_LOW_TAP, 1'b0, 10'd0, VAL_MAX);
        send_word(MODE_HIGH_TAP, 1'b1, 10'd0, VAL_MAX);
        send_word(MODE_LOW_TAP, 1'b1, IDX_LAST, VAL_MIN);
        send_word(MODE_HIGH_TAP, 1'b0, IDX_LAST, VAL_MIN);
        send_word(MODE_LOW_TAP, 1'b0, 10'd1, VAL_MAX);
        send_word(MODE_LOW_TAP, 1'b0, 10'd2, VAL_MAX);
        // drive low and mid into saturation both ways
        send_word(MODE_SAMPLE, 1'b0, 10'd0, VAL_MAX);
        send_word(MODE_SAMPLE, 1'b0, 10'd0, VAL_MAX);
        send_word(MODE_SAMPLE, 1'b0, 10'd0, VAL_MAX);
        send_word(MODE_SAMPLE, 1'b0, 10'd0, VAL_MIN);
        send_word(MODE_SAMPLE, 1'b0, 10'd0, VAL_MIN);
        // tap index past the table end: drop
        send_word(MODE_LOW_TAP, 1'b0, IDX_OUT, VAL_MAX);
        send_word(MODE_HIGH_TAP, 1'b1, IDX_OUT, -24'sd1);
        // unused mode: drop
        send_word(MODE_UNUSED, 1'b1, IDX_OUT, -24'sd1);
        send_word(MODE_UNUSED, 1'b0, 10'd0, 24'sd0);
        send_word(MODE_SAMPLE, 1'b1, 10'd0, 24'sd0);
        send_word(MODE_SAMPLE, 1'b1, IDX_OUT, VAL_MAX);
    endtask

    task automatic test_load_coefs();
        for (int i = 0; i < COEF_WORDS; i++)
        begin
            // first half back to back, second half with gaps
            sender_gaps = (i >= COEF_WORDS / 2);
            send_word($urandom_range(0, 1) ? MODE_LOW_TAP : MODE_HIGH_TAP,
                      1'($urandom_range(0, 1)), 10'($urandom_range(0, TAPS - 1)), pick_coef());
        end
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_stream();
        int          sent;
        int          r;
        logic [1:0]  mode;
        logic        ch;
        logic [9:0]  idx;
        sent = 0;
        // send at least STREAM_WORDS words, and keep going until channel 0 has run past the center tap
        while (sent < STREAM_WORDS || write_slot[0] < HALF_DLY + 16)
        begin
            sender_gaps = ((sent / 40) % 4 != 0);
            r   = $urandom_range(0, 99);
            ch  = 1'($urandom_range(0, 31) == 0);
            idx = 10'($urandom_range(0, 1023));
            if (r < 96)
                mode = MODE_SAMPLE;
            else if (r < 97)
                mode = MODE_LOW_TAP;
            else if (r < 98)
                mode = MODE_HIGH_TAP;
            else
                mode = MODE_UNUSED;
            if (mode == MODE_SAMPLE || mode == MODE_UNUSED)
                send_word(mode, ch, idx, pick_sample());
            else
            begin
                if ($urandom_range(0, 99) < 15)
                    idx = IDX_OUT;
                send_word(mode, 1'($urandom_range(0, 1)), idx, pick_coef());
            end
            sent++;
        end
        sender_gaps = 1'b1;
    endtask

    // receiver: alternate ready stretches with stalls
    initial
    begin
        int on_len;
        int off_len;
        band_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            on_len  = $urandom_range(1, 1500);
            off_len = pick_stall();
            repeat (on_len)
            begin
                @(negedge clk);
                band_bus.ready <= 1'b1;
            end
            repeat (off_len)
            begin
                @(negedge clk);
                band_bus.ready <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_bands
        bands_t want;
        if (rst_n && band_bus.valid && band_bus.ready)
        begin
            if (expected_bands.size() == 0)
            begin
                $error("band word with no sample waiting: channel %0d", band_bus.out_channel);
                fail_count++;
            end
            else
            begin
                want = expected_bands.pop_front();
                bands_checked++;
                if (band_bus.out_channel !== want.channel)
                begin
                    $error("out_channel mismatch: expected %0d actual %0d",
                           want.channel, band_bus.out_channel);
                    fail_count++;
                end
                if (band_bus.low_band !== want.low)
                begin
                    $error("low_band mismatch: expected %0d actual %0d",
                           want.low, band_bus.low_band);
                    fail_count++;
                end
                if (band_bus.mid_band !== want.mid)
                begin
                    $error("mid_band mismatch: expected %0d actual %0d",
                           want.mid, band_bus.mid_band);
                    fail_count++;
                end
                if (band_bus.high_band !== want.high)
                begin
                    $error("high_band mismatch: expected %0d actual %0d",
                           want.high, band_bus.high_band);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int waited;
        sample_bus.valid     = 1'b0;
        sample_bus.mode      = MODE_SAMPLE;
        sample_bus.channel   = 1'b0;
        sample_bus.tap_index = 10'd0;
        sample_bus.value     = '0;
        fail_count    = 0;
        bands_checked = 0;
        coef_writes   = 0;
        ignored_words = 0;
        sender_gaps   = 1'b1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            write_slot[c]   = 0;
            samples_sent[c] = 0;
            for (int k = 0; k < TAPS; k++)
                history[c][k] = '0;
        end
        for (int k = 0; k < TAPS; k++)
        begin
            low_coef[k]  = '0;
            high_coef[k] = '0;
        end

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_load_coefs();
        test_random_stream();
        @(negedge clk);
        sample_bus.valid <= 1'b0;

        waited = 0;
        while (expected_bands.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (FINISH_CYCLES) @(posedge clk);
        if (expected_bands.size() != 0)
        begin
            $error("%0d band words never arrived", expected_bands.size());
            fail_count++;
        end

        $display("Covered %0d band words: %0d samples on channel 0, %0d on channel 1",
                 bands_checked, samples_sent[0], samples_sent[1]);
        $display("Tap writes %0d, dropped words %0d (bad index or unused mode)",
                 coef_writes, ignored_words);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(64'd120_000_000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
